[rtl/core/fra_pkg.sv]
`timescale 1ns / 1ps
// Package for the first-fit region allocator: field widths, codes, word types
// and the command and status structs between controller and datapath.
// No dependencies.
package fra_pkg;

    localparam int MAX_ENTRIES_DEF = 10;
    localparam int MEM_BYTES_DEF   = 1024;

    localparam int MODE_W    = 2;
    localparam int SIZE_W    = 11;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 3;
    localparam int START_W   = 10;
    localparam int LARGEST_W = 11;
    localparam int COUNT_W   = 4;
    localparam int BASE_W    = 10;

    localparam logic [BASE_W-1:0] DATA_BASE_RESET = 10'd160;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_NOP     = 2'd3
    } mode_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOSPACE   = 3'd2,
        ST_BADINDEX  = 3'd3,
        ST_ZERO      = 3'd4
    } status_e_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SIZE_W-1:0]  req_size;
        logic [INDEX_W-1:0] entry_index;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [START_W-1:0]   region_start;
        logic [LARGEST_W-1:0] largest_free;
        logic [COUNT_W-1:0]   entries_used;
    } out_word_t;

    typedef struct packed {
        logic      load;
        logic      scan_init;
        logic      scan_step;
        logic      commit;
        logic      release_entry;
        logic      set_status;
        status_e_t status;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        mode_e_t mode;
        logic    full;
        logic    zero_size;
        logic    bad_index;
        logic    base_out;
        logic    found;
        logic    scan_done;
    } sts_t;

endpackage

[rtl/core/fra_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the first-fit region allocator.
// Depends on fra_pkg for the command, status and code types.
module fra_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  fra_pkg::sts_t sts,
    output fra_pkg::cmd_t cmd
);
    import fra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.status = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next     = S_RESP;
                cmd.set_status = 1'b1;
                case (sts.mode)
                    MODE_ALLOC: begin
                        if (sts.full) begin
                            cmd.status = ST_FULL;
                        end else if (sts.zero_size) begin
                            cmd.status = ST_ZERO;
                        end else if (sts.base_out) begin
                            cmd.status = ST_NOSPACE;
                        end else begin
                            cmd.set_status = 1'b0;
                            cmd.scan_init  = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    MODE_RELEASE: begin
                        if (sts.bad_index) begin
                            cmd.status = ST_BADINDEX;
                        end else begin
                            cmd.release_entry = 1'b1;
                        end
                    end
                    MODE_QUERY: begin
                        if (!sts.base_out) begin
                            cmd.set_status = 1'b0;
                            cmd.scan_init  = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.found) begin
                    cmd.commit     = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next     = S_RESP;
                end else if (sts.scan_done) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = (sts.mode == MODE_ALLOC) ? ST_NOSPACE : ST_OK;
                    state_next     = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/core/fra_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the first-fit region allocator: region table, address scan
// pipeline, free-run counters, base register and result register.
// Depends on fra_pkg for widths, codes and the word and command types.
module fra_datapath #(
    parameter int MAX_ENTRIES = fra_pkg::MAX_ENTRIES_DEF,
    parameter int MEM_BYTES   = fra_pkg::MEM_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fra_pkg::in_word_t            s_data,
    input  logic                         cfg_valid,
    input  logic [fra_pkg::BASE_W-1:0]   cfg_data,
    input  fra_pkg::cmd_t                cmd,
    output fra_pkg::sts_t                sts,
    output fra_pkg::out_word_t           m_data
);
    import fra_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int EW = $clog2(MEM_BYTES + 1);
    localparam int CW = (EW > SIZE_W) ? EW : SIZE_W;
    localparam int BW = (EW > BASE_W) ? EW : BASE_W;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [BASE_W-1:0]  data_base_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [AW-1:0]      starts_reg [MAX_ENTRIES];
    logic [EW-1:0]      ends_reg   [MAX_ENTRIES];

    mode_e_t            mode_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AW-1:0]      start_reg;
    logic [EW-1:0]      best_reg;
    out_word_t          out_reg;

    logic [AW-1:0]      addr_reg;
    logic               issue_reg;
    logic               pv_reg;
    logic               used_reg;
    logic               last_reg;
    logic [AW-1:0]      tag_reg;
    logic [EW-1:0]      run_reg;

    logic               hit;
    logic [EW-1:0]      run_next;
    logic               run_fits;
    logic [AW-1:0]      found_start;
    logic [EW-1:0]      found_end;

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((COUNT_W'(i) < count_reg) && (starts_reg[i] <= addr_reg)
                    && (EW'(addr_reg) < ends_reg[i])) begin
                hit = 1'b1;
            end
        end
    end

    assign run_next    = used_reg ? '0 : run_reg + EW'(1);
    assign run_fits    = CW'(run_next) >= CW'(size_reg);
    assign found_start = AW'(EW'(tag_reg) + EW'(1) - run_next);
    assign found_end   = EW'(found_start) + EW'(size_reg);

    assign sts.mode      = mode_reg;
    assign sts.full      = count_reg >= COUNT_W'(MAX_ENTRIES);
    assign sts.zero_size = (size_reg == '0);
    assign sts.bad_index = index_reg >= count_reg;
    assign sts.base_out  = BW'(data_base_reg) >= BW'(MEM_BYTES);
    assign sts.found     = pv_reg && (mode_reg == MODE_ALLOC) && run_fits;
    assign sts.scan_done = pv_reg && last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_base_reg <= DATA_BASE_RESET;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            pv_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                data_base_reg <= cfg_data;
            end
            if (cmd.scan_init) begin
                issue_reg <= 1'b1;
                pv_reg    <= 1'b0;
            end else if (cmd.scan_step) begin
                pv_reg <= issue_reg;
                if (issue_reg && (addr_reg == AW'(MEM_BYTES - 1))) begin
                    issue_reg <= 1'b0;
                end
            end else begin
                issue_reg <= 1'b0;
                pv_reg    <= 1'b0;
            end
            if (cmd.commit) begin
                count_reg <= count_reg + COUNT_W'(1);
            end else if (cmd.release_entry) begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_e_t'(s_data.mode);
            size_reg   <= s_data.req_size;
            index_reg  <= s_data.entry_index;
            start_reg  <= '0;
            best_reg   <= '0;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.scan_init) begin
            addr_reg <= AW'(data_base_reg);
            run_reg  <= '0;
        end else if (cmd.scan_step) begin
            used_reg <= hit;
            tag_reg  <= addr_reg;
            last_reg <= (addr_reg == AW'(MEM_BYTES - 1));
            addr_reg <= addr_reg + AW'(1);
            if (pv_reg) begin
                run_reg <= run_next;
                if ((mode_reg == MODE_QUERY) && (run_next > best_reg)) begin
                    best_reg <= run_next;
                end
            end
        end
        if (cmd.commit) begin
            start_reg                    <= found_start;
            starts_reg[count_reg[IW-1:0]] <= found_start;
            ends_reg[count_reg[IW-1:0]]   <= found_end;
        end
        if (cmd.release_entry) begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                if (COUNT_W'(i) >= COUNT_W'(index_reg)) begin
                    starts_reg[i] <= starts_reg[i + 1];
                    ends_reg[i]   <= ends_reg[i + 1];
                end
            end
        end
        if (cmd.out_load) begin
            out_reg.status       <= status_reg;
            out_reg.region_start <= START_W'(start_reg);
            out_reg.largest_free <= LARGEST_W'(best_reg);
            out_reg.entries_used <= count_reg;
        end
    end

    assign m_data = out_reg;

endmodule

[rtl/core/first_fit_region_allocator_top.sv]
`timescale 1ns / 1ps
// Top level of the first-fit region allocator: joins controller and datapath.
// Depends on fra_pkg, fra_ctrl and fra_datapath.
//
//   Channel   Ports                        Word
//   input     s_valid, s_ready, s_data     mode, req_size, entry_index
//   result    m_valid, m_ready, m_data     status, region_start, largest_free,
//                                          entries_used
//   config    cfg_valid, cfg_ready, cfg_data   data_base
//
// Release, refused requests, no-op words and queries with data_base out of range skip the scan.
// Allocate and query scan one address a cycle from data_base to MEM_BYTES-1 through
// a two-stage compare pipeline; allocate stops at the first fitting run.
// A new word is accepted once the previous result sits in the output register.
// Reset clears the entry count and sets data_base to 160; configuration is always ready.
module first_fit_region_allocator_top #(
    parameter int MAX_ENTRIES = fra_pkg::MAX_ENTRIES_DEF,
    parameter int MEM_BYTES   = fra_pkg::MEM_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fra_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output fra_pkg::out_word_t         m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fra_pkg::BASE_W-1:0] cfg_data
);
    import fra_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fra_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MEM_BYTES   (MEM_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule
